@@ rtl/cfsa_pkg.sv @@
package cfsa_pkg;

  localparam int RATE_W   = 31;
  localparam int TIME_W   = 32;
  localparam int FINISH_W = 33;
  localparam int COST_W   = 62;
  localparam int TOTAL_W  = 63;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;
  localparam int BUSY_W   = FINISH_W + RATE_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_JOB = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Command to a heap unit: push the data word, or pop the minimum.
  typedef struct packed {
    logic valid;
    logic pop;
  } heap_cmd_t;

endpackage

@@ rtl/cheapest_free_server_allocator_core.sv @@
// Cheapest free server allocator.
// Input items arrive on the s_axis channel. tuser carries the operation: 0 adds
// an idle server whose rate is in tdata, 1 requests a job with an arrival time
// and a duration. Every item produces exactly one result item on m_axis:
// tuser carries the status, tdata the assigned rate, the job cost, the
// saturating running total with its sticky flag, and both server counts.
// Idle servers sit in a min-heap keyed by rate, working servers in a min-heap
// keyed by finish time; each heap lives in its own synchronous memory.
// One item is processed at a time. An add runs a sift-up of the free heap.
// A job runs one round for every busy server it releases, each a sift-down
// of the busy heap alongside a free-heap push, plus one more such round for
// the assignment, and then the multiply and the total update.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls, the block holds the following result
// until the register is free. Synchronous reset empties both heaps and clears
// the total and the saturation flag; no memory clearing pass is needed.
module cheapest_free_server_allocator_core #(
  parameter int NUM_SERVERS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: rate[30:0], arrival_time[62:31], duration[93:63], zero fill
  input  logic [95:0]  s_axis_tdata,
  // tuser: operation[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: assigned_rate[30:0], job_cost[92:31], total_cost[155:93],
  // total_saturated[156], free_servers[167:157], busy_servers[178:168], zero fill
  output logic [183:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int CW = $clog2(NUM_SERVERS + 1);
  localparam int RW = cfsa_pkg::RATE_W;
  localparam int BW = cfsa_pkg::BUSY_W;

  typedef enum logic [6:0] {
    T_IDLE = 7'b0000001,
    T_ADD  = 7'b0000010,
    T_REL  = 7'b0000100,
    T_MUL  = 7'b0001000,
    T_ACC  = 7'b0010000,
    T_WAIT = 7'b0100000,
    T_DONE = 7'b1000000
  } tstate_t;

  tstate_t state;

  logic [RW-1:0]                     rate;
  logic [cfsa_pkg::TIME_W-1:0]       arrival;
  logic [RW-1:0]                     dur;
  logic [cfsa_pkg::STATUS_W-1:0]     status;
  logic [RW-1:0]                     assigned;
  logic [cfsa_pkg::COST_W-1:0]       cost;
  logic [cfsa_pkg::TOTAL_W-1:0]      total;
  logic                              sat;

  cfsa_pkg::heap_cmd_t free_cmd;
  cfsa_pkg::heap_cmd_t busy_cmd;
  logic [RW-1:0]       free_push;
  logic [BW-1:0]       busy_push;
  logic                free_idle;
  logic                busy_idle;
  logic [RW-1:0]       free_top;
  logic [BW-1:0]       busy_top;
  logic [CW-1:0]       free_cnt;
  logic [CW-1:0]       busy_cnt;

  logic                              heaps_idle;
  logic [CW:0]                       used;
  logic                              release_due;
  logic [cfsa_pkg::FINISH_W-1:0]     finish;
  logic [cfsa_pkg::TOTAL_W:0]        sum;

  cfsa_heap #(.DEPTH(NUM_SERVERS), .W(RW)) u_free (
    .clk       (clk),
    .rst       (rst),
    .cmd       (free_cmd),
    .push_data (free_push),
    .idle      (free_idle),
    .top       (free_top),
    .count     (free_cnt)
  );

  cfsa_heap #(.DEPTH(NUM_SERVERS), .W(BW)) u_busy (
    .clk       (clk),
    .rst       (rst),
    .cmd       (busy_cmd),
    .push_data (busy_push),
    .idle      (busy_idle),
    .top       (busy_top),
    .count     (busy_cnt)
  );

  assign heaps_idle  = free_idle && busy_idle;
  assign used        = {1'b0, free_cnt} + {1'b0, busy_cnt};
  // A busy server is released when its finish time is at or before arrival.
  assign release_due = (busy_cnt != '0) &&
                       (busy_top[BW-1:RW] <= {1'b0, arrival});
  assign finish      = {1'b0, arrival} + {2'b00, dur};
  assign sum         = {1'b0, total} + {2'b00, cost};
  assign s_axis_tready = (state == T_IDLE);

  // Heap commands are issued only when both heaps have finished their last
  // operation, so the tops and counts seen here are settled.
  always_comb begin
    free_cmd  = '0;
    busy_cmd  = '0;
    free_push = rate;
    busy_push = {finish, free_top};
    case (state)
      T_ADD: begin
        if (heaps_idle && used < (CW+1)'(NUM_SERVERS)) begin
          free_cmd.valid = 1'b1;
        end
      end
      T_REL: begin
        if (heaps_idle) begin
          if (release_due) begin
            busy_cmd.valid = 1'b1;
            busy_cmd.pop   = 1'b1;
            free_cmd.valid = 1'b1;
            free_push      = busy_top[RW-1:0];
          end else if (free_cnt != '0) begin
            free_cmd.valid = 1'b1;
            free_cmd.pop   = 1'b1;
            busy_cmd.valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      total         <= '0;
      sat           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // In T_DONE a taken result is replaced by the next one below.
      if (m_axis_tvalid && m_axis_tready && state != T_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (s_axis_tvalid) begin
            rate     <= s_axis_tdata[30:0];
            arrival  <= s_axis_tdata[62:31];
            dur      <= s_axis_tdata[93:63];
            status   <= cfsa_pkg::STATUS_OK;
            assigned <= '0;
            cost     <= '0;
            state    <= (s_axis_tuser[0] == cfsa_pkg::OP_JOB) ? T_REL : T_ADD;
          end
        end
        T_ADD: begin
          if (heaps_idle) begin
            if (used >= (CW+1)'(NUM_SERVERS)) begin
              status <= cfsa_pkg::STATUS_FULL;
            end
            state <= T_WAIT;
          end
        end
        T_REL: begin
          if (heaps_idle && !release_due) begin
            if (free_cnt == '0) begin
              status <= cfsa_pkg::STATUS_DROP;
              state  <= T_WAIT;
            end else begin
              assigned <= free_top;
              state    <= T_MUL;
            end
          end
        end
        T_MUL: begin
          cost  <= {{RW{1'b0}}, assigned} * {{RW{1'b0}}, dur};
          state <= T_ACC;
        end
        T_ACC: begin
          if (sum[cfsa_pkg::TOTAL_W]) begin
            total <= cfsa_pkg::TOTAL_MAX;
            sat   <= 1'b1;
          end else begin
            total <= sum[cfsa_pkg::TOTAL_W-1:0];
          end
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (heaps_idle) begin
            state <= T_DONE;
          end
        end
        T_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Result payload register, loaded as the result leaves T_DONE.
  always_ff @(posedge clk) begin
    if (state == T_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {5'b00000,
                       cfsa_pkg::CNT_W'(busy_cnt),
                       cfsa_pkg::CNT_W'(free_cnt),
                       sat, total, cost, assigned};
    end
  end

`ifndef SYNTHESIS
  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    used <= (CW+1)'(NUM_SERVERS))
    else $error("server counts exceed the store size");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    sat |=> sat)
    else $error("saturation flag cleared");

  a_sat_total: assert property (@(posedge clk) disable iff (rst)
    sat |-> total == cfsa_pkg::TOTAL_MAX)
    else $error("saturated total is not at its maximum");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == T_DONE) |-> heaps_idle)
    else $error("result formed while a heap is still sifting");
`endif

endmodule

@@ rtl/cfsa_heap.sv @@
// Binary min-heap in a single-port-read synchronous memory. The minimum is
// mirrored in a register so it can be inspected without a memory read.
// Sifting moves a hole rather than swapping, one level at a time.
module cfsa_heap #(
  parameter int DEPTH = 1024,
  parameter int W = 31,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  cfsa_pkg::heap_cmd_t cmd,
  input  logic [W-1:0]        push_data,
  output logic                idle,
  output logic [W-1:0]        top,
  output logic [CW-1:0]       count
);

  typedef enum logic [6:0] {
    H_IDLE  = 7'b0000001,
    H_PCHK  = 7'b0000010,
    H_PWT   = 7'b0000100,
    H_LWT   = 7'b0001000,
    H_CHK   = 7'b0010000,
    H_LEFT  = 7'b0100000,
    H_RIGHT = 7'b1000000
  } hstate_t;

  hstate_t       state;
  logic [CW-1:0] pos;
  logic [CW-1:0] size;
  logic [W-1:0]  val;
  logic [W-1:0]  left;
  logic [W-1:0]  rdata;

  logic [W-1:0]  mem [DEPTH];

  logic          ren;
  logic [IW-1:0] raddr;
  logic          wen;
  logic [IW-1:0] waddr;
  logic [W-1:0]  wdata;

  logic [CW:0]   child;
  logic [CW:0]   child_r;
  logic [CW-1:0] parent;
  logic [W-1:0]  min_child;
  logic          right_less;

  assign child      = {pos, 1'b1};
  assign child_r    = child + 1'b1;
  assign parent     = (pos - 1'b1) >> 1;
  assign right_less = rdata < left;
  assign min_child  = right_less ? rdata : left;
  assign idle       = (state == H_IDLE);

  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    wen   = 1'b0;
    waddr = pos[IW-1:0];
    wdata = val;
    case (state)
      H_IDLE: begin
        if (cmd.valid && cmd.pop) begin
          ren   = 1'b1;
          raddr = IW'(count - 1'b1);
        end
      end
      H_PCHK: begin
        if (pos == '0) begin
          wen = 1'b1;
        end else begin
          ren   = 1'b1;
          raddr = parent[IW-1:0];
        end
      end
      H_PWT: begin
        wen   = 1'b1;
        wdata = (rdata <= val) ? val : rdata;
      end
      H_CHK: begin
        if (child >= {1'b0, size}) begin
          wen = 1'b1;
        end else begin
          ren   = 1'b1;
          raddr = child[IW-1:0];
        end
      end
      H_LEFT: begin
        if (child_r < {1'b0, size}) begin
          ren   = 1'b1;
          raddr = child_r[IW-1:0];
        end else begin
          wen   = 1'b1;
          wdata = (val <= rdata) ? val : rdata;
        end
      end
      H_RIGHT: begin
        wen   = 1'b1;
        wdata = (val <= min_child) ? val : min_child;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
    if (wen && waddr == '0) begin
      top <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
    end else begin
      case (state)
        H_IDLE: begin
          if (cmd.valid) begin
            if (cmd.pop) begin
              size  <= count - 1'b1;
              count <= count - 1'b1;
              state <= H_LWT;
            end else begin
              pos   <= count;
              val   <= push_data;
              count <= count + 1'b1;
              state <= H_PCHK;
            end
          end
        end
        H_PCHK: begin
          state <= (pos == '0) ? H_IDLE : H_PWT;
        end
        H_PWT: begin
          if (rdata <= val) begin
            state <= H_IDLE;
          end else begin
            pos   <= parent;
            state <= H_PCHK;
          end
        end
        H_LWT: begin
          val <= rdata;
          pos <= '0;
          state <= (size == '0) ? H_IDLE : H_CHK;
        end
        H_CHK: begin
          state <= (child >= {1'b0, size}) ? H_IDLE : H_LEFT;
        end
        H_LEFT: begin
          left <= rdata;
          if (child_r < {1'b0, size}) begin
            state <= H_RIGHT;
          end else if (val <= rdata) begin
            state <= H_IDLE;
          end else begin
            pos   <= child[CW-1:0];
            state <= H_CHK;
          end
        end
        H_RIGHT: begin
          if (val <= min_child) begin
            state <= H_IDLE;
          end else begin
            pos   <= right_less ? child_r[CW-1:0] : child[CW-1:0];
            state <= H_CHK;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

@@ sim/cheapest_free_server_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module cheapest_free_server_allocator_core_tb;

  localparam int NUM_SERVERS = 1024;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [cfsa_pkg::STATUS_W-1:0] status;
    logic [cfsa_pkg::RATE_W-1:0]   assigned_rate;
    logic [cfsa_pkg::COST_W-1:0]   job_cost;
    logic [cfsa_pkg::TOTAL_W-1:0]  total_cost;
    logic                          total_saturated;
    logic [cfsa_pkg::CNT_W-1:0]    free_servers;
    logic [cfsa_pkg::CNT_W-1:0]    busy_servers;
  } alloc_result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [183:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  cheapest_free_server_allocator_core #(.NUM_SERVERS(NUM_SERVERS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the block's state. Heap order does not matter for the
  // results, only the contents, so plain queues hold the servers.
  logic [cfsa_pkg::RATE_W-1:0]  idle_rates[$];
  logic [cfsa_pkg::BUSY_W-1:0]  busy_entries[$];
  logic [cfsa_pkg::TOTAL_W-1:0] cost_total;
  logic                         cost_saturated;
  alloc_result_t                expected_results[$];

  int mismatches;
  int receiver_hold_req;
  int idle_cycles;
  logic [cfsa_pkg::TIME_W-1:0] job_clock;

  // Works out the result of one accepted item and advances the shadow state.
  function automatic alloc_result_t alloc_predict(logic op,
                                                  logic [cfsa_pkg::RATE_W-1:0] rate,
                                                  logic [cfsa_pkg::TIME_W-1:0] arrival,
                                                  logic [cfsa_pkg::RATE_W-1:0] dur);
    alloc_result_t res;
    int            best;
    logic [63:0]   cost;
    logic [cfsa_pkg::FINISH_W-1:0] finish;
    res = '0;
    if (op == cfsa_pkg::OP_ADD) begin
      if (idle_rates.size() + busy_entries.size() >= NUM_SERVERS)
        res.status = cfsa_pkg::STATUS_FULL;
      else
        idle_rates.insert(idle_rates.size(), rate);
    end else begin
      // Release every busy server whose finish time has come.
      for (int i = busy_entries.size() - 1; i >= 0; i--) begin
        if ((busy_entries[i] >> cfsa_pkg::RATE_W) <= {1'b0, arrival}) begin
          idle_rates.insert(idle_rates.size(), busy_entries[i][cfsa_pkg::RATE_W-1:0]);
          busy_entries.delete(i);
        end
      end
      if (idle_rates.size() == 0) begin
        res.status = cfsa_pkg::STATUS_DROP;
      end else begin
        best = 0;
        for (int i = 1; i < idle_rates.size(); i++)
          if (idle_rates[i] < idle_rates[best]) best = i;
        res.assigned_rate = idle_rates[best];
        idle_rates.delete(best);
        cost = 64'(res.assigned_rate) * 64'(dur);
        res.job_cost = cost[cfsa_pkg::COST_W-1:0];
        if (64'(cost_total) > 64'(cfsa_pkg::TOTAL_MAX) - cost) begin
          cost_total = cfsa_pkg::TOTAL_MAX;
          cost_saturated = 1'b1;
        end else begin
          cost_total = cost_total + cost[cfsa_pkg::TOTAL_W-1:0];
        end
        finish = cfsa_pkg::FINISH_W'(arrival) + cfsa_pkg::FINISH_W'(dur);
        busy_entries.insert(busy_entries.size(), {finish, res.assigned_rate});
      end
    end
    res.total_cost = cost_total;
    res.total_saturated = cost_saturated;
    res.free_servers = cfsa_pkg::CNT_W'(idle_rates.size());
    res.busy_servers = cfsa_pkg::CNT_W'(busy_entries.size());
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one item, waits for its handshake, then records the expected result.
  task automatic send_item(logic op, logic [cfsa_pkg::RATE_W-1:0] rate,
                           logic [cfsa_pkg::TIME_W-1:0] arrival,
                           logic [cfsa_pkg::RATE_W-1:0] dur, bit allow_gap = 1);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, dur, arrival, rate};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.insert(expected_results.size(), alloc_predict(op, rate, arrival, dur));
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_server(logic [cfsa_pkg::RATE_W-1:0] rate, bit allow_gap = 1);
    send_item(cfsa_pkg::OP_ADD, rate, $urandom(), cfsa_pkg::RATE_W'($urandom()), allow_gap);
  endtask

  task automatic request_job(logic [cfsa_pkg::TIME_W-1:0] arrival,
                             logic [cfsa_pkg::RATE_W-1:0] dur);
    send_item(cfsa_pkg::OP_JOB, cfsa_pkg::RATE_W'($urandom()), arrival, dur);
  endtask

  // Extremes of every field, drops, ties, releases at the exact finish time,
  // out of order arrivals and the widest finish time.
  task automatic test_directed();
    request_job(32'd0, 31'd5);                 // nothing free: dropped
    add_server(31'd0);
    add_server(31'h7FFF_FFFF);
    add_server(31'd7);
    add_server(31'd7);                         // tie with the previous server
    request_job(32'd10, 31'd0);                // zero rate, zero length
    request_job(32'd10, 31'd20);               // releases the zero-rate server and takes it again
    request_job(32'd11, 31'd4);                // takes one of the tied servers
    request_job(32'd15, 31'd3);                // releases the server done at 15
    request_job(32'd12, 31'd1);                // arrival earlier than the last one
    request_job(32'd30, 31'h7FFF_FFFF);        // releases several at once
    add_server(31'h7FFF_FFFF);
    add_server(31'h7FFF_FFFF);
    add_server(31'h5555_5555);
    add_server(31'h2AAA_AAAA);
    request_job(32'hFFFF_FFFF, 31'h7FFF_FFFF); // widest finish time
    request_job(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    request_job(32'hFFFF_FFFF, 31'h7FFF_FFFF); // takes the other rate-7 server
    request_job(32'hFFFF_FFFF, 31'h7FFF_FFFF); // takes the 2AAA_AAAA server
    request_job(32'hFFFF_FFFF, 31'h7FFF_FFFF);
  endtask

  // Random jobs and adds with a slowly advancing clock, so that servers are
  // released and reused. Adds thin out as the store fills, since it never shrinks.
  task automatic test_random(int count);
    int roll;
    logic [cfsa_pkg::RATE_W-1:0] dur;
    job_clock = 32'd0;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ((idle_rates.size() + busy_entries.size() < 48) ? 30 : 3)) begin
        if ($urandom_range(0, 3) == 0)
          add_server(cfsa_pkg::RATE_W'($urandom()));
        else
          add_server(cfsa_pkg::RATE_W'($urandom_range(0, 1000)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 80) dur = cfsa_pkg::RATE_W'($urandom_range(0, 60));
        else if (roll < 95) dur = cfsa_pkg::RATE_W'($urandom_range(0, 5000));
        else dur = cfsa_pkg::RATE_W'($urandom());
        if ($urandom_range(0, 19) == 0)
          request_job(job_clock - cfsa_pkg::TIME_W'($urandom_range(0, 40)), dur);
        else begin
          job_clock = job_clock + cfsa_pkg::TIME_W'($urandom_range(0, 12));
          request_job(job_clock, dur);
        end
      end
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // block backs up; then the sender waits until every result is in.
  task automatic test_backpressure();
    receiver_hold_req = 3000;
    for (int n = 0; n < 12; n++) begin
      job_clock = job_clock + cfsa_pkg::TIME_W'($urandom_range(0, 8));
      send_item(cfsa_pkg::OP_JOB, cfsa_pkg::RATE_W'($urandom()), job_clock,
                cfsa_pkg::RATE_W'($urandom_range(0, 30)), 0);
    end
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  // Result checker and receiver stall control.
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status          = m_axis_tuser;
        got.assigned_rate   = m_axis_tdata[30:0];
        got.job_cost        = m_axis_tdata[92:31];
        got.total_cost      = m_axis_tdata[155:93];
        got.total_saturated = m_axis_tdata[156];
        got.free_servers    = m_axis_tdata[167:157];
        got.busy_servers    = m_axis_tdata[178:168];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (receiver_hold_req > 0) begin
        m_axis_tready <= 1'b0;
        receiver_hold_req <= receiver_hold_req - 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50);
      end
    end
  end

  // Watchdog on cycles without any accepted item on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("cheapest_free_server_allocator_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    receiver_hold_req = 0;
    idle_cycles = 0;
    job_clock = '0;
    cost_total = '0;
    cost_saturated = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(820);
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("cheapest_free_server_allocator_core regression: pass");
    end else begin
      $display("cheapest_free_server_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
